### hdl/k_way_sorted_merge_assert.svh
// Assertion macros shared by the k-way sorted merge RTL.
// Included by the modules that carry concurrent assertions; needs no package.
`ifndef K_WAY_SORTED_MERGE_ASSERT_SVH
`define K_WAY_SORTED_MERGE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define KWM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define KWM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/kwm_pkg.sv
// Shared constants, types and helpers of the k-way sorted merge block.
// No dependencies; imported by kwm_min_tree, kwm_out_q and the top level.
package kwm_pkg;

    localparam int LISTS      = 16;
    localparam int LIST_DEPTH = 32;

    localparam int SLOTS  = LISTS * LIST_DEPTH;
    localparam int LID_W  = $clog2(LISTS);
    localparam int PTR_W  = $clog2(LIST_DEPTH);
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int ADDR_W = $clog2(SLOTS);

    localparam int VAL_W = 16;
    localparam int IDX_W = 4;
    localparam int REQ_W = 2;
    localparam int ST_W  = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                    found;
        logic [LID_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
    } t_min;

    typedef struct packed {
        logic signed [VAL_W-1:0] merged_value;
        logic [ST_W-1:0]         status;
    } t_result;

    // Store address of one position within one list.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LID_W-1:0] lid,
                                                    input logic [PTR_W-1:0] pos);
        return ADDR_W'(ADDR_W'(lid) * ADDR_W'(LIST_DEPTH) + ADDR_W'(pos));
    endfunction

endpackage

### hdl/kwm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module kwm_ram #(
    parameter int WIDTH  = 16,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/kwm_min_tree.sv
// Registered comparison tree that finds the smallest valid list head.
// Depends on kwm_pkg.
module kwm_min_tree
    import kwm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic signed [VAL_W-1:0] i_head [LISTS],
    input  logic [LISTS-1:0]        i_valid,
    output t_min                    o_min
);

    localparam int LEAVES = 1 << LID_W;

    t_min w_node [2*LEAVES];
    t_min r_min;
    t_min n_min;

    // The left operand always covers lower list indexes, so it wins a tie.
    function automatic t_min pick(input t_min a, input t_min b);
        if (a.found && (!b.found || !(b.val < a.val))) begin
            return a;
        end
        return b;
    endfunction

    always_comb begin
        for (int n = 0; n < 2*LEAVES; n++) begin
            w_node[n] = '0;
        end
        for (int i = 0; i < LEAVES; i++) begin
            if (i < LISTS) begin
                w_node[LEAVES+i].found = i_valid[i];
                w_node[LEAVES+i].idx   = LID_W'(i);
                w_node[LEAVES+i].val   = i_head[i];
            end
        end
        for (int n = LEAVES - 1; n >= 1; n--) begin
            w_node[n] = pick(w_node[2*n], w_node[2*n+1]);
        end
        n_min = w_node[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min.found <= 1'b0;
        end else begin
            r_min.found <= n_min.found;
        end
        r_min.idx <= n_min.idx;
        r_min.val <= n_min.val;
    end

    assign o_min = r_min;

endmodule

### hdl/kwm_out_q.sv
// Two-word result queue that decouples the merge engine from the output stream.
// Depends on kwm_pkg.
module kwm_out_q
    import kwm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result    r_q [2];
    logic       r_wr, n_wr;
    logic       r_rd, n_rd;
    logic [1:0] r_cnt, n_cnt;
    logic       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_q[r_rd];

    always_comb begin
        n_wr  = i_push ? ~r_wr : r_wr;
        n_rd  = w_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + 2'(i_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_q[r_wr] <= i_data;
        end
    end

endmodule

### hdl/k_way_sorted_merge.sv
// Top level of the k-way sorted merge block: request sequencer, list bookkeeping,
// list store, head minimum tree and result queue. Depends on kwm_pkg, kwm_ram,
// kwm_min_tree, kwm_out_q and k_way_sorted_merge_assert.svh.
//
//  Channel   Dir  tdata (low bit first)               tuser
//  s_axis    in   list_index[3:0], value[19:4], pad   req_type[1:0]
//  m_axis    out  merged_value[15:0]                   status[1:0]
//
// Append, clear and unused requests are accepted in S_IDLE and executed in S_EXEC.
// A pop that leaves its list non-empty also passes through S_REFILL, as the list
// store's registered read port must reload that list's head register before the
// next minimum is valid. Reset is synchronous and clears every read pointer, fill
// count and head valid bit; the store needs no clearing pass.
// s_axis_tready is high only when idle and the two-word result queue has room.
`include "k_way_sorted_merge_assert.svh"

module k_way_sorted_merge
    import kwm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Request stream.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // list_index[3:0], value[19:4], zero pad
    input  logic [REQ_W-1:0]     s_axis_tuser,   // req_type[1:0]
    // Result stream.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // merged_value[15:0]
    output logic [ST_W-1:0]      m_axis_tuser    // status[1:0]
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_REFILL = 2'd2;

    logic [1:0] r_state, n_state;

    // The accepted request word.
    logic [REQ_W-1:0]        r_in_req, n_in_req;
    logic [IDX_W-1:0]        r_in_idx, n_in_idx;
    logic signed [VAL_W-1:0] r_in_val, n_in_val;

    // Per-list bookkeeping: head pointer, fill count, cached head value and
    // its valid bit. The list contents themselves live in the store.
    logic [PTR_W-1:0]        r_rp   [LISTS];
    logic [PTR_W-1:0]        n_rp   [LISTS];
    logic [CNT_W-1:0]        r_fill [LISTS];
    logic [CNT_W-1:0]        n_fill [LISTS];
    logic signed [VAL_W-1:0] r_head [LISTS];
    logic signed [VAL_W-1:0] n_head [LISTS];
    logic [LISTS-1:0]        r_hv, n_hv;
    logic [LID_W-1:0]        r_cur, n_cur;

    t_min    w_min;
    t_result w_res;
    t_result w_q_data;
    logic    w_push;
    logic    w_q_full;
    logic    w_accept;

    // Store port signals.
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [VAL_W-1:0]  w_rdata;

    // Append path.
    logic [LID_W-1:0] w_lid;
    logic             w_idx_ok;
    logic             w_full;
    logic [SUM_W-1:0] w_app_sum;
    logic [PTR_W-1:0] w_app_pos;

    // Pop path.
    logic [LID_W-1:0] w_b;
    logic [SUM_W-1:0] w_pop_inc;
    logic [PTR_W-1:0] w_pop_next;
    logic [CNT_W-1:0] w_pop_left;

    logic [LISTS-1:0] w_nonempty;

    assign s_axis_tready = (r_state == S_IDLE) && !w_q_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    // An out-of-range list index is answered as if the list were full.
    assign w_lid     = LID_W'(r_in_idx);
    assign w_idx_ok  = 32'(r_in_idx) < 32'(LISTS);
    assign w_full    = !w_idx_ok || (r_fill[w_lid] >= CNT_W'(LIST_DEPTH));
    assign w_app_sum = SUM_W'(r_rp[w_lid]) + SUM_W'(r_fill[w_lid]);
    assign w_app_pos = (w_app_sum >= SUM_W'(LIST_DEPTH)) ?
                       PTR_W'(w_app_sum - SUM_W'(LIST_DEPTH)) : PTR_W'(w_app_sum);

    // The winner was registered in the accept cycle from heads that had
    // already settled, so it is current here.
    assign w_b        = w_min.idx;
    assign w_pop_inc  = SUM_W'(r_rp[w_b]) + SUM_W'(1);
    assign w_pop_next = (w_pop_inc == SUM_W'(LIST_DEPTH)) ? '0 : PTR_W'(w_pop_inc);
    assign w_pop_left = r_fill[w_b] - CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_in_req = r_in_req;
        n_in_idx = r_in_idx;
        n_in_val = r_in_val;
        n_rp     = r_rp;
        n_fill   = r_fill;
        n_head   = r_head;
        n_hv     = r_hv;
        n_cur    = r_cur;
        w_push   = 1'b0;
        w_res    = '0;
        w_we     = 1'b0;
        w_waddr  = slot_addr(w_lid, w_app_pos);
        w_re     = 1'b0;
        w_raddr  = slot_addr(w_b, w_pop_next);

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_in_req = s_axis_tuser;
                    n_in_idx = s_axis_tdata[IDX_W-1:0];
                    n_in_val = s_axis_tdata[IDX_W+VAL_W-1:IDX_W];
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                w_push  = 1'b1;
                n_state = S_IDLE;
                unique case (r_in_req)
                    REQ_APPEND: begin
                        if (w_full) begin
                            w_res.status = ST_FULL;
                        end else begin
                            w_we = 1'b1;
                            n_fill[w_lid] = r_fill[w_lid] + CNT_W'(1);
                            // An empty list takes the new word straight as its head.
                            if (r_fill[w_lid] == '0) begin
                                n_head[w_lid] = r_in_val;
                                n_hv[w_lid]   = 1'b1;
                            end
                        end
                    end
                    REQ_POP: begin
                        if (!w_min.found) begin
                            w_res.status = ST_EMPTY;
                        end else begin
                            w_res.merged_value = w_min.val;
                            n_rp[w_b]   = w_pop_next;
                            n_fill[w_b] = w_pop_left;
                            if (w_pop_left != '0) begin
                                w_re    = 1'b1;
                                n_cur   = w_b;
                                n_state = S_REFILL;
                            end else begin
                                n_hv[w_b] = 1'b0;
                            end
                        end
                    end
                    REQ_CLEAR: begin
                        for (int i = 0; i < LISTS; i++) begin
                            n_rp[i]   = '0;
                            n_fill[i] = '0;
                        end
                        n_hv = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_REFILL: begin
                n_head[r_cur] = w_rdata;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hv    <= '0;
            for (int i = 0; i < LISTS; i++) begin
                r_rp[i]   <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_hv    <= n_hv;
            r_rp    <= n_rp;
            r_fill  <= n_fill;
        end
        r_in_req <= n_in_req;
        r_in_idx <= n_in_idx;
        r_in_val <= n_in_val;
        r_head   <= n_head;
        r_cur    <= n_cur;
    end

    // Accesses to the store never overlap: a write happens only in an append's
    // execute cycle and a read only in a pop's, so no forwarding is needed.
    kwm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_in_val),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    kwm_min_tree u_min (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (r_head),
        .i_valid (r_hv),
        .o_min   (w_min)
    );

    kwm_out_q u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_res),
        .o_full  (w_q_full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_q_data)
    );

    assign m_axis_tdata = w_q_data.merged_value;
    assign m_axis_tuser = w_q_data.status;

    always_comb begin
        for (int i = 0; i < LISTS; i++) begin
            w_nonempty[i] = (r_fill[i] != '0);
        end
    end

    // A cached head is valid exactly when its list holds at least one word.
    `KWM_ASSERT_IMP(a_head_valid, i_clk, i_rst_n, 1'b1, w_nonempty == r_hv, "head valid bits disagree with fill counts")
    // An accepted word is executed in the very next cycle.
    `KWM_ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC, "accepted word not executed next cycle")
    // A reload only targets a list that still holds words.
    `KWM_ASSERT_IMP(a_refill_list, i_clk, i_rst_n, r_state == S_REFILL, (r_fill[r_cur] != '0) && r_hv[r_cur], "head reload on an empty list")
    // The result queue always has room when a result is produced.
    `KWM_ASSERT_IMP(a_push_room, i_clk, i_rst_n, w_push, !w_q_full, "result pushed into a full queue")

endmodule
